// ===== rtl/core/aip_pkg.sv =====
// ----------------------------------------------------------------------------
// aip_pkg: shared types, constants and helpers
// Character codes, configuration layout and the front-to-back operation
// record of the integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int MAX_RADIX = 16;
    localparam int MIN_RADIX = 2;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = $clog2(MAX_RADIX);
    localparam int LEN_W     = 5;
    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CHARS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 2'd2;

    typedef struct packed {
        logic [CFG_DAT_W-1:0] low_chars;
        logic [CFG_DAT_W-1:0] high_chars;
        logic [LEN_W-1:0]     length;
    } cfg_t;

    // One queued operation: either a digit to fold in, or a terminator
    typedef struct packed {
        logic               is_emit;
        logic               negative;
        logic [DIGIT_W-1:0] digit;
    } op_t;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [CHAR_W-1:0] alpha_char(input cfg_t cfg,
                                                     input logic [DIGIT_W-1:0] k);
        logic [2*CFG_DAT_W-1:0] all;
        all = {cfg.high_chars, cfg.low_chars};
        return all[k*CHAR_W +: CHAR_W];
    endfunction

endpackage

// ===== rtl/core/aip_ch_if.sv =====
// ----------------------------------------------------------------------------
// aip_ch_if: character input channel
// Valid/ready transfer of one character.
// ----------------------------------------------------------------------------
interface aip_ch_if;
    import aip_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

// ===== rtl/core/aip_res_if.sv =====
// ----------------------------------------------------------------------------
// aip_res_if: result channel
// Valid/ready transfer of one parsed value and the alphabet status.
// ----------------------------------------------------------------------------
interface aip_res_if;
    import aip_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      alphabet_ok;

    modport source (output valid, output value, output alphabet_ok, input ready);
    modport sink   (input valid, input value, input alphabet_ok, output ready);
endinterface

// ===== rtl/core/aip_cfg_if.sv =====
// ----------------------------------------------------------------------------
// aip_cfg_if: configuration write channel
// Valid/ready transfer of a register index and its write data.
// ----------------------------------------------------------------------------
interface aip_cfg_if;
    import aip_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ascii_any_base_integer_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_any_base_integer_parser: string-to-integer over a custom alphabet
// Skips whitespace, reads signs, folds alphabet digits into a 32-bit value
// and emits the signed result on each NUL character.
// ----------------------------------------------------------------------------
// Usage:
//   chars   : one character per transfer. Every character is consumed; only
//             the NUL terminator produces a transfer on results.
//   results : signed 32-bit value plus alphabet_ok. With an invalid alphabet
//             (length below 2 or above 16, a sign, whitespace or NUL in use,
//             or a repeated character) value is 0 and alphabet_ok is 0.
//   cfg     : register writes, always ready. Index 0 holds digit characters
//             0..7, index 1 digits 8..15, index 2 the radix. Write only while
//             no string is in flight; the validity flag is a registered check.
// Throughput is one character per cycle while the queue has room: the front
// classifies a character in the cycle it arrives, and the back folds one
// digit per cycle with a single 32x5 multiply-add. A NUL passes a queue slot,
// then the result register, on its way to results.
// When results stalls, the held result stays put and digits behind it keep
// draining; a second NUL waits in the two-entry queue, and chars drops ready
// only once that queue is full.
// Reset clears phase, sign, accumulator, configuration, queue pointers and flags
// (not queue or result data), leaving the alphabet invalid until configured.
// ----------------------------------------------------------------------------
module ascii_any_base_integer_parser (
    input  logic      clk,
    input  logic      rst_n,
    aip_ch_if.sink    chars,
    aip_res_if.source results,
    aip_cfg_if.sink   cfg
);
    import aip_pkg::*;

    cfg_t cfg_reg;
    logic ok_reg, ok_next;

    logic push;
    op_t  push_op;
    logic q_full;
    logic head_valid;
    op_t  head_op;
    logic pop;

    // Configuration registers; writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_LOW_CHARS:  cfg_reg.low_chars  <= cfg.data;
                CFG_HIGH_CHARS: cfg_reg.high_chars <= cfg.data;
                CFG_LENGTH:     cfg_reg.length     <= cfg.data[LEN_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Alphabet check: length range, forbidden characters, duplicates.
    // Registered from the configuration registers, so it settles after a write lands.
    always_comb
    begin
        logic [CHAR_W-1:0] ci;
        ok_next = (cfg_reg.length >= LEN_W'(MIN_RADIX)) &&
                  (cfg_reg.length <= LEN_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            ci = alpha_char(cfg_reg, DIGIT_W'(i));
            if (LEN_W'(i) < cfg_reg.length)
            begin
                if ((ci == CH_NUL) || (ci == CH_PLUS) || (ci == CH_MINUS) || is_ws(ci))
                begin
                    ok_next = 1'b0;
                end
                for (int j = i + 1; j < MAX_RADIX; j++)
                begin
                    if ((LEN_W'(j) < cfg_reg.length) &&
                        (alpha_char(cfg_reg, DIGIT_W'(j)) == ci))
                    begin
                        ok_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else
        begin
            ok_reg <= ok_next;
        end
    end

    // Front: classify each character, push digit and terminator operations
    aip_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .push    (push),
        .push_op (push_op)
    );

    // Decouple classification from accumulation
    aip_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop)
    );

    // Back: fold digits, emit results
    aip_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .alphabet_ok (ok_reg),
        .head_valid  (head_valid),
        .head_op     (head_op),
        .pop         (pop),
        .results     (results)
    );

endmodule

// ===== rtl/core/aip_front.sv =====
// ----------------------------------------------------------------------------
// aip_front: character classifier
// Tracks the parse phase and sign, looks up digits, and pushes digit and
// terminator operations into the queue.
// ----------------------------------------------------------------------------
module aip_front (
    input  logic          clk,
    input  logic          rst_n,
    aip_ch_if.sink        chars,
    input  aip_pkg::cfg_t cfg,
    input  logic          q_full,
    output logic          push,
    output aip_pkg::op_t  push_op
);
    import aip_pkg::*;

    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [1:0]         phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic               accept;
    logic               hit;
    logic [DIGIT_W-1:0] digit;
    logic [LEN_W-1:0]   radix;
    logic               gen;

    assign chars.ready = !q_full;
    assign accept      = chars.valid && chars.ready;

    assign radix = (cfg.length > LEN_W'(MAX_RADIX)) ? LEN_W'(MAX_RADIX) : cfg.length;

    // Parallel compare against the alphabet, lowest index wins
    always_comb
    begin
        hit   = 1'b0;
        digit = '0;
        for (int k = MAX_RADIX - 1; k >= 0; k--)
        begin
            if ((LEN_W'(k) < radix) && (alpha_char(cfg, DIGIT_W'(k)) == chars.ch))
            begin
                hit   = 1'b1;
                digit = DIGIT_W'(k);
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        gen        = 1'b0;
        push_op    = '{is_emit: 1'b0, negative: neg_reg, digit: digit};
        if (chars.ch == CH_NUL)
        begin
            gen             = 1'b1;
            push_op.is_emit = 1'b1;
            phase_next      = PH_SPACE;
            neg_next        = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SPACE, PH_SIGN:
                begin
                    if ((phase_reg == PH_SPACE) && is_ws(chars.ch))
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (chars.ch == CH_PLUS)
                    begin
                        phase_next = PH_SIGN;
                    end
                    else if (chars.ch == CH_MINUS)
                    begin
                        phase_next = PH_SIGN;
                        neg_next   = !neg_reg;
                    end
                    else if (hit)
                    begin
                        phase_next = PH_DIGIT;
                        gen        = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DIGIT:
                begin
                    if (hit)
                    begin
                        gen = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_SPACE;
                end
            endcase
        end
    end

    assign push = accept && gen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
        end
    end

    // A terminator always leaves the parser back in whitespace skipping
    a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (chars.ch == CH_NUL) |=> (phase_reg == PH_SPACE) && !neg_reg)
        else $error("terminator did not restart the parser");

endmodule

// ===== rtl/core/aip_queue.sv =====
// ----------------------------------------------------------------------------
// aip_queue: operation queue
// Two-entry FIFO between the classifier and the accumulator.
// ----------------------------------------------------------------------------
module aip_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  aip_pkg::op_t push_op,
    output logic         full,
    output logic         head_valid,
    output aip_pkg::op_t head_op,
    input  logic         pop
);
    import aip_pkg::*;

    op_t                mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

// ===== rtl/core/aip_back.sv =====
// ----------------------------------------------------------------------------
// aip_back: accumulator and result stage
// Folds digits into the running value and drives the result register.
// ----------------------------------------------------------------------------
module aip_back (
    input  logic          clk,
    input  logic          rst_n,
    input  aip_pkg::cfg_t cfg,
    input  logic          alphabet_ok,
    input  logic          head_valid,
    input  aip_pkg::op_t  head_op,
    output logic          pop,
    aip_res_if.source     results
);
    import aip_pkg::*;

    logic [VALUE_W-1:0]        acc_reg;
    logic [VALUE_W-1:0]        acc_mac;
    logic [VALUE_W-1:0]        signed_acc;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_ok_reg;
    logic                      out_free;

    assign out_free = !out_valid_reg || results.ready;
    assign pop      = head_valid && (!head_op.is_emit || out_free);

    // One narrow multiply-add per digit, wrapping modulo 2^32
    assign acc_mac    = VALUE_W'(acc_reg * VALUE_W'(cfg.length)) + VALUE_W'(head_op.digit);
    assign signed_acc = head_op.negative ? (VALUE_W'(0) - acc_reg) : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (pop)
        begin
            acc_reg <= head_op.is_emit ? '0 : acc_mac;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && head_op.is_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_op.is_emit)
        begin
            out_value_reg <= alphabet_ok ? signed_acc : '0;
            out_ok_reg    <= alphabet_ok;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.value       = out_value_reg;
    assign results.alphabet_ok = out_ok_reg;

    a_bad_alphabet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ok_reg |-> (out_value_reg == '0))
        else $error("nonzero value with invalid alphabet");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_op.is_emit |=> (acc_reg == '0) && out_valid_reg)
        else $error("terminator did not clear the accumulator");

endmodule
